[design/protected_space_access_table_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the protected space access table
// Implication checks sampled on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PROTECTED_SPACE_ACCESS_TABLE_ASSERT_SVH
`define PROTECTED_SPACE_ACCESS_TABLE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define PSAT_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication
`define PSAT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`else

`define PSAT_ASSERT_SAME(lbl, pre, post, msg)
`define PSAT_ASSERT_NEXT(lbl, pre, post, msg)

`endif

`endif

[design/psat_pkg.sv]
// ----------------------------------------------------------------------------
// psat_pkg
// Shared constants and types of the protected space access table.
// ----------------------------------------------------------------------------
`default_nettype none

package psat_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_ENTRIES);

  localparam int KEY_W  = 64;
  localparam int FLAG_W = 16;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [FLAG_W-1:0] method;
    logic [FLAG_W-1:0] mask;
  } psat_entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    psat_entry_t       wr_data;
  } psat_mem_req_t;

  typedef struct packed {
    logic [1:0]        operation;
    logic [KEY_W-1:0]  target_key;
    logic [KEY_W-1:0]  accessor_key;
    logic [FLAG_W-1:0] method_flags;
    logic [FLAG_W-1:0] blocked_mask;
    logic [FLAG_W-1:0] access_type;
  } psat_item_t;

endpackage

`default_nettype wire

[design/psat_mem.sv]
// ----------------------------------------------------------------------------
// psat_mem
// Entry store: key, method flags and mask, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module psat_mem
  import psat_pkg::*;
(
  input  wire logic          clk,
  input  wire psat_mem_req_t req,
  output psat_entry_t        rd_data
);

  psat_entry_t mem [TABLE_ENTRIES];
  psat_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[design/psat_ctrl.sv]
// ----------------------------------------------------------------------------
// psat_ctrl
// Scan sequencer: valid marks, lookup over the entry store, update, result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "protected_space_access_table_assert.svh"

module psat_ctrl
  import psat_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire psat_item_t    in_item,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [1:0]         out_status,
  output logic               out_blocked,
  output psat_mem_req_t      mem_req,
  input  wire psat_entry_t   mem_rd_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0]               state_r, state_nxt;
  psat_item_t               item_r;
  logic [CNT_W-1:0]         iss_cnt_r, iss_cnt_nxt;
  logic                     pend_r, pend_nxt;
  logic [IDX_W-1:0]         pend_idx_r, pend_idx_nxt;
  logic                     found_r, found_nxt;
  logic [IDX_W-1:0]         hit_idx_r, hit_idx_nxt;
  logic [FLAG_W-1:0]        hit_mask_r, hit_mask_nxt;
  logic                     free_r, free_nxt;
  logic [IDX_W-1:0]         free_idx_r, free_idx_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r, out_status_nxt;
  logic                     out_blocked_r, out_blocked_nxt;

  logic issue, hit, out_free, fin;

  assign in_ready  = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign fin       = (state_r == S_FINISH) && out_free;
  assign issue     = (state_r == S_SCAN) && (iss_cnt_r != SCAN_END);
  assign hit       = pend_r && valid_r[pend_idx_r] && (mem_rd_data.key == item_r.target_key);

  always_comb begin
    state_nxt       = state_r;
    iss_cnt_nxt     = iss_cnt_r;
    pend_nxt        = 1'b0;
    pend_idx_nxt    = pend_idx_r;
    found_nxt       = found_r;
    hit_idx_nxt     = hit_idx_r;
    hit_mask_nxt    = hit_mask_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    valid_nxt       = valid_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_blocked_nxt = out_blocked_r;

    mem_req.rd_en   = issue;
    mem_req.rd_addr = iss_cnt_r[IDX_W-1:0];
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = hit_idx_r;
    mem_req.wr_data.key    = item_r.target_key;
    mem_req.wr_data.method = item_r.method_flags;
    mem_req.wr_data.mask   = item_r.blocked_mask;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt   = S_SCAN;
          iss_cnt_nxt = '0;
          found_nxt   = 1'b0;
          free_nxt    = 1'b0;
        end
      end
      S_SCAN: begin
        if (issue) begin
          iss_cnt_nxt  = iss_cnt_r + CNT_W'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = iss_cnt_r[IDX_W-1:0];
        end
        // read data arrives the cycle after its address; keep the lowest hit
        if (hit && !found_r) begin
          found_nxt    = 1'b1;
          hit_idx_nxt  = pend_idx_r;
          hit_mask_nxt = mem_rd_data.mask;
        end
        if (pend_r && !valid_r[pend_idx_r] && !free_r) begin
          free_nxt     = 1'b1;
          free_idx_nxt = pend_idx_r;
        end
        if (!issue && !pend_r) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt       = S_IDLE;
          out_valid_nxt   = 1'b1;
          out_status_nxt  = ST_OK;
          out_blocked_nxt = 1'b0;
          unique case (item_r.operation)
            OP_ADD: begin
              if (found_r) begin
                mem_req.wr_en = 1'b1;
              end else if (free_r) begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = free_idx_r;
              end else begin
                out_status_nxt = ST_FULL;
              end
              if (mem_req.wr_en) begin
                valid_nxt[mem_req.wr_addr] = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (found_r) begin
                valid_nxt[hit_idx_r] = 1'b0;
              end else begin
                out_status_nxt = ST_NOT_FOUND;
              end
            end
            OP_QUERY: begin
              out_blocked_nxt = found_r && (item_r.accessor_key != item_r.target_key) &&
                                (|(hit_mask_r & item_r.access_type));
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_cnt_r   <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      free_r      <= free_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
    pend_idx_r    <= pend_idx_nxt;
    hit_idx_r     <= hit_idx_nxt;
    hit_mask_r    <= hit_mask_nxt;
    free_idx_r    <= free_idx_nxt;
    out_status_r  <= out_status_nxt;
    out_blocked_r <= out_blocked_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_blocked = out_blocked_r;

  `PSAT_ASSERT_SAME(a_wr_only_add, mem_req.wr_en, fin && (item_r.operation == OP_ADD), "entry write outside an add")
  `PSAT_ASSERT_SAME(a_rd_in_range, mem_req.rd_en, iss_cnt_r < SCAN_END, "read issued past the table")
  `PSAT_ASSERT_SAME(a_full_means_full, fin && (out_status_nxt == ST_FULL), &valid_r, "table full reported with a free slot")
  `PSAT_ASSERT_NEXT(a_wr_sets_valid, mem_req.wr_en, valid_r[$past(mem_req.wr_addr)], "written entry not marked valid")

endmodule

`default_nettype wire

[design/protected_space_access_table.sv]
// ----------------------------------------------------------------------------
// protected_space_access_table
// Table of protected address spaces with add, remove and access query.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  in_      | slave     | tuser: operation; tdata: keys, flags, mask, access type
//  out_     | master    | tdata: status, blocked
//
// After acceptance in_tready stays low through the entry scan and the finish state;
// the entry scan reads one entry a cycle through the single read port of the entry
// store. Reset clears the valid marks at once, no clearing pass. A finished result
// waits in the output register while the next beat is accepted; the block only
// stalls in its finish state if the output is held.
// ----------------------------------------------------------------------------
`default_nettype none

module protected_space_access_table
  import psat_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [63:0] target_key, [127:64] accessor_key, [143:128] method_flags,
  // [159:144] blocked_mask, [175:160] access_type
  input  wire logic [175:0] in_tdata,
  // [1:0] operation
  input  wire logic [1:0]   in_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [1:0] status, [2] blocked, [7:3] zero
  output logic [7:0]        out_tdata
);

  psat_item_t    item;
  psat_mem_req_t mem_req;
  psat_entry_t   mem_rd_data;
  logic [1:0]    status;
  logic          blocked;

  assign item.operation    = in_tuser;
  assign item.target_key   = in_tdata[63:0];
  assign item.accessor_key = in_tdata[127:64];
  assign item.method_flags = in_tdata[143:128];
  assign item.blocked_mask = in_tdata[159:144];
  assign item.access_type  = in_tdata[175:160];

  psat_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_item     (item),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (status),
    .out_blocked (blocked),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data)
  );

  psat_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  assign out_tdata = {5'b0, blocked, status};

endmodule

`default_nettype wire
